[src/sfcs_pkg.sv]
// Package for the subsumption-filtered clause store.
// Holds the literal width used by all units and the input and result word types of the top level.
// No dependencies.
package sfcs_pkg;

  localparam int unsigned LitW     = 64;
  localparam int unsigned InDepthW = 7;
  localparam int unsigned CntOutW  = 9;

  typedef struct packed {
    logic [LitW-1:0]     pos_lits;
    logic [LitW-1:0]     neg_lits;
    logic [InDepthW-1:0] clause_depth;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic               store_full;
    logic [CntOutW-1:0] killed_count;
    logic [CntOutW-1:0] live_count;
  } out_t;

endpackage

[src/sfcs_cmp.sv]
// Shared subsumption compare unit: literal subset test plus depth order.
// Used by both scans of the clause store; depends on sfcs_pkg.
module sfcs_cmp #(
  parameter int unsigned DEPTH_BITS = 7
) (
  input  logic [sfcs_pkg::LitW-1:0] sub_pos_i,
  input  logic [sfcs_pkg::LitW-1:0] sub_neg_i,
  input  logic [DEPTH_BITS-1:0]     sub_depth_i,
  input  logic [sfcs_pkg::LitW-1:0] sup_pos_i,
  input  logic [sfcs_pkg::LitW-1:0] sup_neg_i,
  input  logic [DEPTH_BITS-1:0]     sup_depth_i,
  output logic                      hit_o
);

  logic subset;

  assign subset = ((sub_pos_i & ~sup_pos_i) == '0) && ((sub_neg_i & ~sup_neg_i) == '0);
  assign hit_o  = subset && (sub_depth_i <= sup_depth_i);

endmodule

[src/sfcs_store.sv]
// Clause memory: one write port, one registered read port.
// Each word holds the positive mask, negative mask, depth and live bit of a slot.
// Depends on sfcs_pkg.
module sfcs_store #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DEPTH_BITS = 7
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr_i,
  input  logic [sfcs_pkg::LitW-1:0]   wr_pos_i,
  input  logic [sfcs_pkg::LitW-1:0]   wr_neg_i,
  input  logic [DEPTH_BITS-1:0]       wr_depth_i,
  input  logic                        wr_live_i,
  input  logic                        rd_en_i,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr_i,
  output logic [sfcs_pkg::LitW-1:0]   rd_pos_o,
  output logic [sfcs_pkg::LitW-1:0]   rd_neg_o,
  output logic [DEPTH_BITS-1:0]       rd_depth_o,
  output logic                        rd_live_o
);

  localparam int unsigned WordW = 2 * sfcs_pkg::LitW + DEPTH_BITS + 1;

  logic [WordW-1:0] mem_q [CAPACITY];
  logic [WordW-1:0] rd_word_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_live_i, wr_depth_i, wr_neg_i, wr_pos_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_word_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_pos_o   = rd_word_q[sfcs_pkg::LitW-1:0];
  assign rd_neg_o   = rd_word_q[2*sfcs_pkg::LitW-1:sfcs_pkg::LitW];
  assign rd_depth_o = rd_word_q[WordW-2:2*sfcs_pkg::LitW];
  assign rd_live_o  = rd_word_q[WordW-1];

endmodule

[src/subsumption_filtered_clause_store.sv]
// Subsumption-filtered clause store. Each offered clause (positive mask, negative
// mask, depth) runs two scans over the clause memory, one entry per cycle through
// its single registered read port and one shared subset/depth compare unit: first
// a reject scan (a live entry subsumes the offer at no greater depth), then, unless
// rejected, a kill pass that retires every live entry the offer subsumes and finds
// the lowest free slot; the offer is then written there, or flagged as store full
// if no slot is free. The input is not ready while a word is being processed.
// After reset the block clears the live bits of the memory before it accepts its
// first word. A finished result sits in an output register, and the next word may
// be accepted meanwhile.
// Depends on sfcs_pkg, sfcs_cmp and sfcs_store.
module subsumption_filtered_clause_store #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DEPTH_BITS = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sfcs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sfcs_pkg::out_t out_data_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned OutW = sfcs_pkg::CntOutW;
  localparam logic [AW-1:0] Last = AW'(CAPACITY - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_REJ   = 3'd2;
  localparam logic [2:0] S_KILL  = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic                        issue_q, issue_d;
  logic                        rd_vld_q;
  logic [AW-1:0]               ridx_q;
  logic                        reject_q, reject_d;
  logic                        have_slot_q, have_slot_d;
  logic [AW-1:0]               slot_q, slot_d;
  logic [CntW-1:0]             killed_q, killed_d;
  logic [CntW-1:0]             live_q, live_d;
  logic                        full_q, full_d;
  logic                        acc_q, acc_d;
  logic [sfcs_pkg::LitW-1:0]   off_pos_q, off_neg_q;
  logic [DEPTH_BITS-1:0]       off_depth_q;
  logic                        out_valid_q;
  sfcs_pkg::out_t              out_q;

  logic [DEPTH_BITS+sfcs_pkg::InDepthW-1:0] depth_ext;
  logic [CntW+OutW-1:0]                     killed_ext, live_ext;

  logic                      accept_in, issue, pass_end, hit, ent_hit, out_free;
  logic                      wr_en, wr_live;
  logic [AW-1:0]             wr_addr;
  logic [sfcs_pkg::LitW-1:0] rd_pos, rd_neg;
  logic [DEPTH_BITS-1:0]     rd_depth;
  logic                      rd_live;
  logic                      scan_rej;
  logic [sfcs_pkg::LitW-1:0] sub_pos, sub_neg, sup_pos, sup_neg;
  logic [DEPTH_BITS-1:0]     sub_depth, sup_depth;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept_in  = in_valid_i && in_ready_o;
  assign issue      = issue_q && ((state_q == S_REJ) || (state_q == S_KILL));
  assign pass_end   = rd_vld_q && (ridx_q == Last);
  assign out_free   = !out_valid_q || out_ready_i;

  // Keep only the low DEPTH_BITS bits of the offered depth.
  assign depth_ext = {{DEPTH_BITS{1'b0}}, in_data_i.clause_depth};

  // Swap compare operands between the two scans.
  assign scan_rej  = (state_q == S_REJ);
  assign sub_pos   = scan_rej ? rd_pos      : off_pos_q;
  assign sub_neg   = scan_rej ? rd_neg      : off_neg_q;
  assign sub_depth = scan_rej ? rd_depth    : off_depth_q;
  assign sup_pos   = scan_rej ? off_pos_q   : rd_pos;
  assign sup_neg   = scan_rej ? off_neg_q   : rd_neg;
  assign sup_depth = scan_rej ? off_depth_q : rd_depth;

  sfcs_cmp #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_cmp (
    .sub_pos_i   (sub_pos),
    .sub_neg_i   (sub_neg),
    .sub_depth_i (sub_depth),
    .sup_pos_i   (sup_pos),
    .sup_neg_i   (sup_neg),
    .sup_depth_i (sup_depth),
    .hit_o       (hit)
  );

  assign ent_hit = rd_vld_q && rd_live && hit;

  assign wr_en   = (state_q == S_CLEAR) || (state_q == S_WR) ||
                   ((state_q == S_KILL) && ent_hit);
  assign wr_addr = (state_q == S_CLEAR) ? idx_q :
                   (state_q == S_KILL)  ? ridx_q : slot_q;
  assign wr_live = (state_q == S_WR);

  sfcs_store #(
    .CAPACITY   (CAPACITY),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_pos_i   (off_pos_q),
    .wr_neg_i   (off_neg_q),
    .wr_depth_i (off_depth_q),
    .wr_live_i  (wr_live),
    .rd_en_i    (issue),
    .rd_addr_i  (idx_q),
    .rd_pos_o   (rd_pos),
    .rd_neg_o   (rd_neg),
    .rd_depth_o (rd_depth),
    .rd_live_o  (rd_live)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    issue_d     = issue_q;
    reject_d    = reject_q;
    have_slot_d = have_slot_q;
    slot_d      = slot_q;
    killed_d    = killed_q;
    live_d      = live_q;
    full_d      = full_q;
    acc_d       = acc_q;

    if (issue) begin
      idx_d = idx_q + AW'(1);
      if (idx_q == Last) begin
        issue_d = 1'b0;
      end
    end

    unique case (state_q)
      S_CLEAR: begin
        idx_d = idx_q + AW'(1);
        if (idx_q == Last) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept_in) begin
          idx_d       = '0;
          issue_d     = 1'b1;
          reject_d    = 1'b0;
          have_slot_d = 1'b0;
          killed_d    = '0;
          full_d      = 1'b0;
          acc_d       = 1'b0;
          state_d     = S_REJ;
        end
      end
      S_REJ: begin
        if (ent_hit) begin
          reject_d = 1'b1;
        end
        if (pass_end) begin
          idx_d = '0;
          if (reject_q || ent_hit) begin
            state_d = S_OUT;
          end else begin
            issue_d = 1'b1;
            state_d = S_KILL;
          end
        end
      end
      S_KILL: begin
        if (ent_hit) begin
          killed_d = killed_q + CntW'(1);
          live_d   = live_q - CntW'(1);
        end
        // First slot that is free after this pass is the lowest free index.
        if (rd_vld_q && (!rd_live || hit) && !have_slot_q) begin
          have_slot_d = 1'b1;
          slot_d      = ridx_q;
        end
        if (pass_end) begin
          if (have_slot_q || !rd_live || hit) begin
            state_d = S_WR;
          end else begin
            full_d  = 1'b1;
            state_d = S_OUT;
          end
        end
      end
      S_WR: begin
        live_d  = live_q + CntW'(1);
        acc_d   = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      reject_q    <= 1'b0;
      have_slot_q <= 1'b0;
      killed_q    <= '0;
      live_q      <= '0;
      full_q      <= 1'b0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      issue_q     <= issue_d;
      rd_vld_q    <= issue;
      reject_q    <= reject_d;
      have_slot_q <= have_slot_d;
      killed_q    <= killed_d;
      live_q      <= live_d;
      full_q      <= full_d;
      acc_q       <= acc_d;
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign killed_ext = {{OutW{1'b0}}, killed_q};
  assign live_ext   = {{OutW{1'b0}}, live_q};

  // Payload registers: hold the offer and the pending result word.
  always_ff @(posedge clk_i) begin
    ridx_q <= idx_q;
    slot_q <= slot_d;
    if (accept_in) begin
      off_pos_q   <= in_data_i.pos_lits;
      off_neg_q   <= in_data_i.neg_lits;
      off_depth_q <= depth_ext[DEPTH_BITS-1:0];
    end
    if ((state_q == S_OUT) && out_free) begin
      out_q.accepted     <= acc_q;
      out_q.store_full   <= full_q;
      out_q.killed_count <= killed_ext[OutW-1:0];
      out_q.live_count   <= live_ext[OutW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/tb_subsumption_filtered_clause_store.sv]
// Testbench for subsumption_filtered_clause_store: random and directed clause words,
// checked against an in-bench prediction of the clause store with bursty input and
// stalling output. Depends on sfcs_pkg and the top level of the block.
module tb_subsumption_filtered_clause_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY     = 256;
  localparam int unsigned DEPTH_BITS   = 7;
  localparam logic [6:0]  DEPTH_MASK   = 7'((1 << DEPTH_BITS) - 1);
  localparam int          ERAS         = 15;
  localparam int          FILL_ERA     = 3;
  localparam int          ERA_WORDS    = 55;
  localparam int          FILL_WORDS   = 300;
  localparam int          LIMIT_CYCLES = 10_000_000;
  localparam int          MAX_PRINTS   = 50;

  localparam logic [63:0] ONES  = '1;
  localparam logic [63:0] ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] ALT_5 = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TOP   = 64'h8000_0000_0000_0000;

  typedef enum {OFFER_FRESH, OFFER_SUPERSET, OFFER_SUBSET, OFFER_COPY, OFFER_NEAR,
                OFFER_TAUT} offer_kind_e;
  typedef enum {DENS_SPARSE, DENS_HALF, DENS_DENSE} density_e;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  sfcs_pkg::in_t  in_word = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  sfcs_pkg::out_t out_word;

  // shadow of the clause store
  logic [63:0] slot_pos   [CAPACITY];
  logic [63:0] slot_neg   [CAPACITY];
  logic [6:0]  slot_depth [CAPACITY];
  bit          slot_live  [CAPACITY];
  int unsigned live_total = 0;

  sfcs_pkg::in_t  offer_q[$];
  sfcs_pkg::out_t pending_outcomes[$];

  int unsigned n_words = 0, n_stored = 0, n_subsumed = 0, n_full = 0;
  int unsigned n_killed = 0, peak_killed = 0, peak_live = 0;
  int unsigned n_results = 0, errors = 0;

  subsumption_filtered_clause_store #(
    .CAPACITY   (CAPACITY),
    .DEPTH_BITS (DEPTH_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  always #6 clk_i = ~clk_i;

  task automatic flag(string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_field(string field, logic [8:0] got, logic [8:0] want);
    if (got !== want) flag($sformatf("result %0d: %s is %0d, expected %0d",
                                     n_results, field, got, want));
  endtask

  // Apply one clause word to the shadow store and return the result it causes.
  function automatic sfcs_pkg::out_t settle_offer(sfcs_pkg::in_t w);
    sfcs_pkg::out_t r;
    logic [6:0]     d;
    bit             subsumed;
    int unsigned    killed;
    int             slot;
    r = '0;
    d = w.clause_depth & DEPTH_MASK;
    subsumed = 1'b0;
    killed = 0;
    slot = -1;
    n_words++;
    for (int i = 0; i < CAPACITY; i++)
      if (slot_live[i] && (slot_pos[i] & ~w.pos_lits) == '0 &&
          (slot_neg[i] & ~w.neg_lits) == '0 && slot_depth[i] <= d)
        subsumed = 1'b1;
    if (subsumed) begin
      n_subsumed++;
    end else begin
      for (int i = 0; i < CAPACITY; i++)
        if (slot_live[i] && (w.pos_lits & ~slot_pos[i]) == '0 &&
            (w.neg_lits & ~slot_neg[i]) == '0 && d <= slot_depth[i]) begin
          slot_live[i] = 1'b0;
          killed++;
        end
      live_total -= killed;
      for (int i = CAPACITY - 1; i >= 0; i--)
        if (!slot_live[i]) slot = i;
      if (slot < 0) begin
        r.store_full = 1'b1;
        n_full++;
      end else begin
        slot_pos[slot]   = w.pos_lits;
        slot_neg[slot]   = w.neg_lits;
        slot_depth[slot] = d;
        slot_live[slot]  = 1'b1;
        live_total++;
        r.accepted     = 1'b1;
        r.killed_count = 9'(killed);
        n_stored++;
        n_killed += killed;
        if (killed > peak_killed) peak_killed = killed;
      end
    end
    if (live_total > peak_live) peak_live = live_total;
    r.live_count = 9'(live_total);
    return r;
  endfunction

  function automatic logic [63:0] lit_mask(density_e dens);
    case (dens)
      DENS_SPARSE: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      DENS_DENSE:  return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      default:     return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_slot();
    int k;
    if (live_total == 0) return -1;
    k = $urandom_range(0, live_total - 1);
    for (int i = 0; i < CAPACITY; i++)
      if (slot_live[i]) begin
        if (k == 0) return i;
        k--;
      end
    return -1;
  endfunction

  // Build a word aimed at the current store contents: supersets get rejected,
  // subsets kill, fresh clauses fill free slots.
  function automatic sfcs_pkg::in_t make_offer(int lo, int hi, bit fill);
    sfcs_pkg::in_t w;
    offer_kind_e   kind;
    int            s;
    int unsigned   roll;
    int unsigned   bit_ix;
    w.clause_depth = 7'($urandom_range(lo, hi));
    s = pick_slot();
    roll = $urandom_range(0, 99);
    kind = roll < 35 ? OFFER_FRESH : roll < 55 ? OFFER_SUPERSET : roll < 75 ? OFFER_SUBSET :
           roll < 85 ? OFFER_COPY : roll < 95 ? OFFER_NEAR : OFFER_TAUT;
    if (fill && roll < 85) kind = OFFER_FRESH;
    if (s < 0 && kind != OFFER_TAUT) kind = OFFER_FRESH;
    case (kind)
      OFFER_FRESH: begin
        if (fill) begin
          w.pos_lits = lit_mask(DENS_HALF);
          w.neg_lits = lit_mask(DENS_HALF);
        end else begin
          w.pos_lits = lit_mask(density_e'($urandom_range(0, 2)));
          w.neg_lits = lit_mask(density_e'($urandom_range(0, 2)));
        end
      end
      OFFER_SUPERSET: begin
        w.pos_lits = slot_pos[s] | lit_mask(DENS_SPARSE);
        w.neg_lits = slot_neg[s] | lit_mask(DENS_SPARSE);
      end
      OFFER_SUBSET, OFFER_NEAR: begin
        w.pos_lits = slot_pos[s] & lit_mask(DENS_DENSE);
        w.neg_lits = slot_neg[s] & lit_mask(DENS_DENSE);
        if (kind == OFFER_NEAR) begin
          bit_ix = $urandom_range(0, 63);
          if ($urandom_range(0, 1)) w.pos_lits[bit_ix] = 1'b1;
          else w.neg_lits[bit_ix] = 1'b1;
        end
      end
      OFFER_COPY: begin
        w.pos_lits = slot_pos[s];
        w.neg_lits = slot_neg[s];
      end
      default: begin
        w.pos_lits = lit_mask(density_e'($urandom_range(0, 2)));
        w.neg_lits = w.pos_lits;
      end
    endcase
    return w;
  endfunction

  // Hand one word to the sender and wait until the block has taken it,
  // so the shadow store is current when the next word is built.
  task automatic send_word(sfcs_pkg::in_t w);
    offer_q.push_back(w);
    do @(negedge clk_i); while (offer_q.size() != 0 || in_valid);
  endtask

  task automatic wait_settled();
    while (pending_outcomes.size() != 0) @(negedge clk_i);
  endtask

  // Sender: bursts of words separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    int unsigned gap_left;
    int unsigned burst_left;
    int unsigned r;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (in_valid && in_ready) pending_outcomes.push_back(settle_offer(in_word));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (offer_q.size() != 0) begin
          in_word  <= offer_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            r = $urandom_range(0, 9);
            gap_left = r < 5 ? 0 : r < 8 ? $urandom_range(1, 20) : $urandom_range(0, 400);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern changes per segment; check each word taken.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int unsigned    seg_left;
    int unsigned    mode;
    sfcs_pkg::out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      seg_left  = 0;
      mode      = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_outcomes.size() == 0) begin
          flag($sformatf("result %0d arrived with nothing expected", n_results));
        end else begin
          want = pending_outcomes.pop_front();
          check_field("accepted", 9'(out_word.accepted), 9'(want.accepted));
          check_field("store_full", 9'(out_word.store_full), 9'(want.store_full));
          check_field("killed_count", out_word.killed_count, want.killed_count);
          check_field("live_count", out_word.live_count, want.live_count);
        end
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 600);
        mode = $urandom_range(0, 7);
      end
      seg_left--;
      case (mode)
        0, 1, 2: out_ready <= 1'b1;
        3, 4:    out_ready <= 1'($urandom_range(0, 1));
        5, 6:    out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= 1'b0;
      endcase
    end
  end

  initial begin
    int lo;
    int hi;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, rejection, kills, tautologies, empty clause
    send_word(sfcs_pkg::in_t'{ONES, ONES, 7'd0});
    send_word(sfcs_pkg::in_t'{ONES, ONES, 7'd127});
    send_word(sfcs_pkg::in_t'{ONES, 64'd0, 7'd127});
    send_word(sfcs_pkg::in_t'{64'd0, ONES, 7'd127});
    send_word(sfcs_pkg::in_t'{TOP, 64'd0, 7'd125});
    send_word(sfcs_pkg::in_t'{TOP | 64'd1, 64'd0, 7'd126});
    send_word(sfcs_pkg::in_t'{TOP | 64'd1, 64'd0, 7'd124});
    send_word(sfcs_pkg::in_t'{TOP, 64'd0, 7'd124});
    send_word(sfcs_pkg::in_t'{64'd0, 64'd0, 7'd127});
    send_word(sfcs_pkg::in_t'{64'd0, 64'd1, 7'd127});
    send_word(sfcs_pkg::in_t'{64'd0, 64'd1 | (64'd1 << 40), 7'd120});
    send_word(sfcs_pkg::in_t'{64'd0, 64'd0, 7'd123});
    send_word(sfcs_pkg::in_t'{ALT_A, ALT_5, 7'd121});
    send_word(sfcs_pkg::in_t'{ALT_5, ALT_5, 7'd121});
    send_word(sfcs_pkg::in_t'{ALT_5, ALT_5, 7'd121});
    send_word(sfcs_pkg::in_t'{ALT_5, ALT_5, 7'd120});
    send_word(sfcs_pkg::in_t'{64'd1, 64'd1, 7'd127});
    send_word(sfcs_pkg::in_t'{64'd0, 64'd0, 7'd122});

    // Each era works in its own depth band; it opens with an empty clause just
    // above the band, which kills everything left from earlier eras.
    for (int era = 0; era < ERAS; era++) begin
      lo = 112 - 8 * era;
      hi = lo + 7;
      wait_settled();
      send_word(sfcs_pkg::in_t'{64'd0, 64'd0, 7'(lo + 8)});
      for (int k = 0; k < (era == FILL_ERA ? FILL_WORDS : ERA_WORDS); k++)
        send_word(make_offer(lo, hi, era == FILL_ERA));
    end

    wait_settled();
    repeat (2 * CAPACITY + 16) @(posedge clk_i);
    $display("covered %0d clause words: %0d stored, %0d subsumed, %0d rejected as full",
             n_words, n_stored, n_subsumed, n_full);
    $display("entries killed: %0d in all, at most %0d by one word; peak occupancy %0d",
             n_killed, peak_killed, peak_live);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("timeout with %0d results outstanding", pending_outcomes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[subsumption_filtered_clause_store.f]
src/sfcs_pkg.sv
src/sfcs_cmp.sv
src/sfcs_store.sv
src/subsumption_filtered_clause_store.sv
tb/tb_subsumption_filtered_clause_store.sv
